FILE: sv/cmm_pkg.sv
// ----------------------------------------------------------------------------
// cmm_pkg: shared types and constants
// Address map constants, item and state types for the memory map block.
// ----------------------------------------------------------------------------
package cmm_pkg;

  localparam int unsigned RAM_BYTES    = 4194304;
  localparam int unsigned RAM_AW       = $clog2(RAM_BYTES);
  localparam int unsigned SP_MEM_BYTES = 4096;
  localparam int unsigned SP_AW        = $clog2(SP_MEM_BYTES);
  localparam int unsigned ROM_BYTES    = 16777216;
  localparam int unsigned ROM_AW       = $clog2(ROM_BYTES);
  localparam int unsigned DMA_LEN_BITS = 24;

  localparam logic [31:0] PHYS_MASK = 32'h1FFF_FFFF;
  localparam logic [31:0] RCR_BASE  = 32'h03F0_0000;
  localparam logic [31:0] SPD_BASE  = 32'h0400_0000;
  localparam logic [31:0] SPI_BASE  = 32'h0400_1000;
  localparam logic [31:0] MI_BASE   = 32'h0430_0000;
  localparam logic [31:0] PI_BASE   = 32'h0460_0000;
  localparam logic [31:0] RI_BASE   = 32'h0470_0000;
  localparam int unsigned RCR_LEN   = 40;
  localparam int unsigned MI_LEN    = 16;
  localparam int unsigned PI_LEN    = 52;
  localparam int unsigned RI_LEN    = 32;
  localparam logic [5:0]  PI_LEN_IDX = 6'd15;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_PHYS = 2'd1;
  localparam logic [1:0] ST_SEG  = 2'd2;

  localparam logic [1:0] CFG_ORDER = 2'd0;
  localparam logic [1:0] CFG_SIZE  = 2'd1;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_LOAD  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    R_NONE, R_RAM, R_RCR, R_SPD, R_SPI, R_MI, R_PI, R_RI, R_ROM
  } region_e;

  typedef enum logic [3:0] {
    S_IDLE, S_BYTE, S_RWAIT, S_DSET, S_DREAD, S_DWRITE, S_STEP, S_LOAD, S_DONE
  } state_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [31:0] addr;
    logic [1:0]  size;
    logic [63:0] wdata;  // first byte in bits 63:56
    logic        sext;
  } item_t;

endpackage

FILE: sv/cmm_front.sv
// ----------------------------------------------------------------------------
// cmm_front: command intake
// Accepts commands, aligns write data and queues items for the engine.
// ----------------------------------------------------------------------------
module cmm_front import cmm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [1:0]  command_i,
  input  logic [31:0] address_i,
  input  logic [1:0]  access_size_i,
  input  logic [63:0] write_data_i,
  input  logic        sign_extend_i,
  output logic        busy_o,
  output logic        avail_o,
  output item_t       item_o,
  input  logic        pop_i
);

  item_t      fifo_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  item_t      in_item;

  assign busy_o  = (cnt_q == 2'd2);
  assign avail_o = (cnt_q != 2'd0);
  assign item_o  = fifo_q[rd_q];
  assign push    = start_i && !busy_o;

  always_comb begin
    in_item.cmd  = cmd_e'(command_i);
    in_item.addr = address_i;
    in_item.size = access_size_i;
    in_item.sext = sign_extend_i;
    if (cmd_e'(command_i) == CMD_LOAD) begin
      // A load stores only the low byte of the write data, whatever the size.
      in_item.wdata = write_data_i << 56;
    end else begin
      unique case (access_size_i)
        2'd0:    in_item.wdata = write_data_i << 56;
        2'd1:    in_item.wdata = write_data_i << 48;
        2'd2:    in_item.wdata = write_data_i << 32;
        default: in_item.wdata = write_data_i;
      endcase
    end
  end

  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = (pop_i && avail_o) ? ~rd_q : rd_q;
    cnt_d = cnt_q + 2'(push) - 2'(pop_i && avail_o);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_q] <= in_item;
    end
  end

endmodule

FILE: sv/cmm_back.sv
// ----------------------------------------------------------------------------
// cmm_back: access engine
// Walks the bytes of each item through the physical map, runs PI copies and ROM loads.
// ----------------------------------------------------------------------------
module cmm_back import cmm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        avail_i,
  input  item_t       item_i,
  output logic        pop_o,
  input  logic [1:0]  rom_order_i,
  input  logic [24:0] rom_size_i,
  output logic        done_o,
  output logic [63:0] read_data_o,
  output logic [1:0]  status_o,
  output logic        dma_ran_o
);

  logic [7:0] ram_mem [RAM_BYTES];
  logic [7:0] spd_mem [SP_MEM_BYTES];
  logic [7:0] spi_mem [SP_MEM_BYTES];
  logic [7:0] rom_mem [ROM_BYTES];
  logic [7:0] rcr_q [RCR_LEN];
  logic [7:0] mi_q  [MI_LEN];
  logic [7:0] pi_q  [PI_LEN];
  logic [7:0] ri_q  [RI_LEN];

  state_e  st_q, st_d;
  item_t   it_q, it_d;
  logic [2:0]  idx_q, idx_d;
  logic [63:0] rdata_q, rdata_d;
  logic [63:0] wsh_q, wsh_d;
  logic        bphys_q, bphys_d, bseg_q, bseg_d, ran_q, ran_d;
  logic [31:0] dst_q, dst_d, src_q, src_d;
  logic [DMA_LEN_BITS-1:0] len_q, len_d, k_q, k_d;

  logic [31:0] va, acc_p, off;
  logic        mapped, acc_we, last, pi_hit;
  logic [7:0]  acc_wd, reg_byte, got_byte;
  region_e     region, sel_q;
  logic [7:0]  ram_rd_q, spd_rd_q, spi_rd_q, rom_rd_q, reg_rd_q;
  logic [2:0]  nlast;
  logic [31:0] kx;

  assign va     = it_q.addr + 32'(idx_q);
  assign mapped = (va[31:30] == 2'b10);
  assign kx     = 32'(k_q);
  assign nlast  = 3'((4'd1 << it_q.size) - 4'd1);
  assign last   = (idx_q == nlast);

  // Physical address and write request of the shared byte port
  always_comb begin
    acc_p  = va & PHYS_MASK;
    acc_we = 1'b0;
    acc_wd = wsh_q[63:56];
    unique case (st_q)
      S_BYTE:   acc_we = (it_q.cmd == CMD_WRITE) && mapped;
      S_DREAD:  acc_p = src_q + kx;
      S_DWRITE: begin
        acc_p  = dst_q + kx;
        acc_we = 1'b1;
        acc_wd = got_byte;
      end
      default: ;
    endcase
  end

  always_comb begin
    region = R_NONE;
    if (acc_p < 32'(RAM_BYTES)) begin
      region = R_RAM;
    end else if (acc_p[31:6] == RCR_BASE[31:6] && acc_p[5:0] < 6'(RCR_LEN)) begin
      region = R_RCR;
    end else if (acc_p[31:12] == SPD_BASE[31:12]) begin
      region = R_SPD;
    end else if (acc_p[31:12] == SPI_BASE[31:12]) begin
      region = R_SPI;
    end else if (acc_p[31:4] == MI_BASE[31:4]) begin
      region = R_MI;
    end else if (acc_p[31:6] == PI_BASE[31:6] && acc_p[5:0] < 6'(PI_LEN)) begin
      region = R_PI;
    end else if (acc_p[31:5] == RI_BASE[31:5]) begin
      region = R_RI;
    end else if (acc_p[31:28] == 4'h1 && acc_p[27:22] != 6'h3F &&
                 {4'd0, acc_p[27:0]} < 32'(ROM_BYTES) &&
                 acc_p[27:0] < {3'd0, rom_size_i}) begin
      region = R_ROM;
    end
  end

  assign pi_hit = (st_q == S_BYTE) && acc_we && region == R_PI && acc_p[5:0] == PI_LEN_IDX;

  always_comb begin
    unique case (region)
      R_RCR:   reg_byte = rcr_q[acc_p[5:0]];
      R_MI:    reg_byte = mi_q[acc_p[3:0]];
      R_PI:    reg_byte = pi_q[acc_p[5:0]];
      R_RI:    reg_byte = ri_q[acc_p[4:0]];
      default: reg_byte = 8'hFF;
    endcase
  end

  always_comb begin
    unique case (sel_q)
      R_RAM:   got_byte = ram_rd_q;
      R_SPD:   got_byte = spd_rd_q;
      R_SPI:   got_byte = spi_rd_q;
      R_ROM:   got_byte = rom_rd_q;
      R_RCR, R_MI, R_PI, R_RI: got_byte = reg_rd_q;
      default: got_byte = 8'hFF;
    endcase
  end

  always_ff @(posedge clk_i) begin
    ram_rd_q <= ram_mem[acc_p[RAM_AW-1:0]];
    spd_rd_q <= spd_mem[acc_p[SP_AW-1:0]];
    spi_rd_q <= spi_mem[acc_p[SP_AW-1:0]];
    rom_rd_q <= rom_mem[acc_p[ROM_AW-1:0]];
    reg_rd_q <= reg_byte;
    sel_q    <= region;
    if (acc_we) begin
      unique case (region)
        R_RAM:   ram_mem[acc_p[RAM_AW-1:0]] <= acc_wd;
        R_SPD:   spd_mem[acc_p[SP_AW-1:0]] <= acc_wd;
        R_SPI:   spi_mem[acc_p[SP_AW-1:0]] <= acc_wd;
        default: ;
      endcase
    end
    if (st_q == S_LOAD && off < 32'(ROM_BYTES)) begin
      rom_mem[off[ROM_AW-1:0]] <= it_q.wdata[63:56];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < RCR_LEN; i++) rcr_q[i] <= 8'd0;
      for (int i = 0; i < MI_LEN; i++)  mi_q[i]  <= 8'd0;
      for (int i = 0; i < PI_LEN; i++)  pi_q[i]  <= 8'd0;
      for (int i = 0; i < RI_LEN; i++)  ri_q[i]  <= 8'd0;
    end else if (acc_we) begin
      unique case (region)
        R_RCR:   rcr_q[acc_p[5:0]] <= acc_wd;
        R_MI:    mi_q[acc_p[3:0]]  <= acc_wd;
        R_PI:    pi_q[acc_p[5:0]]  <= acc_wd;
        R_RI:    ri_q[acc_p[4:0]]  <= acc_wd;
        default: ;
      endcase
    end
  end

  // The load offset is flipped according to the ROM byte order.
  always_comb begin
    unique case (rom_order_i)
      2'd1:    off = it_q.addr ^ 32'd3;
      2'd2:    off = it_q.addr ^ 32'd1;
      default: off = it_q.addr;
    endcase
  end

  // Next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      S_IDLE: begin
        if (avail_i) begin
          unique case (item_i.cmd)
            CMD_READ, CMD_WRITE: st_d = S_BYTE;
            CMD_LOAD:            st_d = S_LOAD;
            default:             st_d = S_DONE;
          endcase
        end
      end
      S_BYTE: begin
        if (it_q.cmd == CMD_READ && mapped) st_d = S_RWAIT;
        else if (pi_hit)                    st_d = S_DSET;
        else if (last)                      st_d = S_DONE;
      end
      S_RWAIT, S_STEP: st_d = last ? S_DONE : S_BYTE;
      S_DSET:   st_d = S_DREAD;
      S_DREAD:  st_d = S_DWRITE;
      S_DWRITE: st_d = (k_q == len_q) ? S_STEP : S_DREAD;
      S_LOAD:   st_d = S_DONE;
      default:  st_d = S_IDLE;
    endcase
  end

  // Datapath updates
  always_comb begin
    it_d    = it_q;
    idx_d   = idx_q;
    rdata_d = rdata_q;
    wsh_d   = wsh_q;
    bphys_d = bphys_q;
    bseg_d  = bseg_q;
    ran_d   = ran_q;
    dst_d   = dst_q;
    src_d   = src_q;
    len_d   = len_q;
    k_d     = k_q;
    pop_o   = 1'b0;
    unique case (st_q)
      S_IDLE: begin
        pop_o   = avail_i;
        it_d    = item_i;
        wsh_d   = item_i.wdata;
        idx_d   = 3'd0;
        rdata_d = 64'd0;
        bphys_d = 1'b0;
        bseg_d  = 1'b0;
        ran_d   = 1'b0;
      end
      S_BYTE: begin
        if (!mapped) begin
          bseg_d = 1'b1;
          if (it_q.cmd == CMD_READ) rdata_d = {rdata_q[55:0], 8'hFF};
        end else if (it_q.cmd == CMD_WRITE && region != R_RAM && region != R_RCR &&
                     region != R_SPD && region != R_SPI && region != R_MI &&
                     region != R_PI && region != R_RI) begin
          bphys_d = 1'b1;
        end
        if (pi_hit) ran_d = 1'b1;
        if (!(it_q.cmd == CMD_READ && mapped) && !pi_hit) begin
          idx_d = idx_q + 3'd1;
          wsh_d = wsh_q << 8;
        end
      end
      S_RWAIT, S_STEP: begin
        if (st_q == S_RWAIT) begin
          rdata_d = {rdata_q[55:0], got_byte};
          if (sel_q == R_NONE) bphys_d = 1'b1;
        end
        idx_d = idx_q + 3'd1;
        wsh_d = wsh_q << 8;
      end
      S_DSET: begin
        dst_d = {pi_q[0], pi_q[1], pi_q[2], pi_q[3]};
        src_d = {pi_q[4], pi_q[5], pi_q[6], pi_q[7]};
        len_d = DMA_LEN_BITS'({pi_q[12], pi_q[13], pi_q[14], pi_q[15]});
        k_d   = '0;
      end
      S_DWRITE: k_d = k_q + 1'b1;
      S_LOAD:   if (off >= 32'(ROM_BYTES)) bphys_d = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    it_q    <= it_d;
    idx_q   <= idx_d;
    rdata_q <= rdata_d;
    wsh_q   <= wsh_d;
    bphys_q <= bphys_d;
    bseg_q  <= bseg_d;
    ran_q   <= ran_d;
    dst_q   <= dst_d;
    src_q   <= src_d;
    len_q   <= len_d;
    k_q     <= k_d;
  end

  assign done_o    = (st_q == S_DONE);
  assign dma_ran_o = ran_q;
  assign status_o  = bseg_q ? ST_SEG : (bphys_q ? ST_PHYS : ST_OK);

  always_comb begin
    read_data_o = rdata_q;
    if (it_q.sext) begin
      unique case (it_q.size)
        2'd0:    read_data_o = {{56{rdata_q[7]}}, rdata_q[7:0]};
        2'd1:    read_data_o = {{48{rdata_q[15]}}, rdata_q[15:0]};
        2'd2:    read_data_o = {{32{rdata_q[31]}}, rdata_q[31:0]};
        default: read_data_o = rdata_q;
      endcase
    end
  end

endmodule

FILE: sv/console_memory_map_with_pi_dma_core.sv
// ----------------------------------------------------------------------------
// console_memory_map_with_pi_dma_core: console memory map with PI copy engine
// Byte-serial bus accesses over RAM, processor memories, registers and ROM.
// ----------------------------------------------------------------------------
//  channel   signals                                      direction
//  command   start_i busy_o command_i address_i ...        in
//  result    done_o read_data_o status_o dma_ran_o         out
//  config    cfg_valid_i cfg_ready_o cfg_index_i cfg_data_i in
//
// A read of a mapped byte passes through S_BYTE and then S_RWAIT for the
// registered memory data; a byte outside the mapped segment and a written byte
// pass through S_BYTE only, and a load through S_LOAD. A PI copy reads and then
// writes each copied byte through the single byte port into the memories.
// A two-entry queue takes commands while the engine works; busy_o is high
// when it is full. Reset clears the register files and configuration; the
// memories are not cleared. The result strobe cannot be stalled.
module console_memory_map_with_pi_dma_core import cmm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  command_i,
  input  logic [31:0] address_i,
  input  logic [1:0]  access_size_i,
  input  logic [63:0] write_data_i,
  input  logic        sign_extend_i,
  output logic        done_o,
  output logic [63:0] read_data_o,
  output logic [1:0]  status_o,
  output logic        dma_ran_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [24:0] cfg_data_i
);

  logic [1:0]  rom_order_q;
  logic [24:0] rom_size_q;
  logic        avail, pop;
  item_t       item;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rom_order_q <= 2'd0;
      rom_size_q  <= 25'd0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_ORDER) rom_order_q <= cfg_data_i[1:0];
      if (cfg_index_i == CFG_SIZE)  rom_size_q  <= cfg_data_i;
    end
  end

  cmm_front u_front (
    .clk_i, .rst_ni, .start_i, .command_i, .address_i, .access_size_i,
    .write_data_i, .sign_extend_i, .busy_o,
    .avail_o(avail), .item_o(item), .pop_i(pop)
  );

  cmm_back u_back (
    .clk_i, .rst_ni, .avail_i(avail), .item_i(item), .pop_o(pop),
    .rom_order_i(rom_order_q), .rom_size_i(rom_size_q),
    .done_o, .read_data_o, .status_o, .dma_ran_o
  );

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> status_o != 2'd3) else $error("invalid status code");

  a_copy_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && dma_ran_o |-> read_data_o == 64'd0)
    else $error("copy reported with read data");

endmodule

FILE: tb/tb_console_memory_map_with_pi_dma_core.sv
// ----------------------------------------------------------------------------
// tb_console_memory_map_with_pi_dma_core: memory map and PI copy testbench
// Drives read, write, ROM load and no-op commands through the memory map, keeps
// its own byte-level copy of every region, predicts each result, and compares it
// with the result strobe across phases of ROM format, ROM size and idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_console_memory_map_with_pi_dma_core;
  import cmm_pkg::*;

  localparam logic [31:0] ROM_BASE_ADDR = 32'h1000_0000;
  localparam logic [31:0] ROM_END_ADDR  = 32'h1FC0_0000;
  localparam logic [31:0] KSEG_LO       = 32'h8000_0000;
  localparam logic [31:0] KSEG_HI       = 32'hC000_0000;
  localparam logic [31:0] KSEG_UNCACHED = 32'hA000_0000;
  localparam int unsigned MAX_COPY      = 64;
  localparam int unsigned CYCLE_LIMIT   = 3000000;
  localparam int unsigned PHASE_ITEMS   = 340;

  typedef struct packed {
    logic [63:0] rdata;
    logic [1:0]  st;
    logic        ran;
  } access_res_t;

  typedef struct packed {
    item_t       it;
    access_res_t res;
  } access_t;

  typedef struct packed {
    logic [31:0] key;
    logic        had;
    logic [7:0]  old;
  } undo_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [1:0]  command_i = '0;
  logic [31:0] address_i = '0;
  logic [1:0]  access_size_i = '0;
  logic [63:0] write_data_i = '0;
  logic        sign_extend_i = 1'b0;
  logic        done_o;
  logic [63:0] read_data_o;
  logic [1:0]  status_o;
  logic        dma_ran_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [24:0] cfg_data_i = '0;

  // Byte image of the whole physical space, keyed by physical address.
  // An entry absent from a memory region has never been written.
  logic [7:0]  phys_img[logic [31:0]];
  undo_t       undo_log[$];
  logic        touches_unwritten;
  logic [1:0]  rom_order;
  logic [24:0] rom_valid;

  access_t     pending_q[$];
  access_res_t awaited_q[$];
  int unsigned idle_pct = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;

  console_memory_map_with_pi_dma_core u_top (.*);

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic decodes(logic [31:0] p, logic wr);
    logic rom_ok;
    rom_ok = !wr && p >= ROM_BASE_ADDR && p < ROM_END_ADDR &&
             (p - ROM_BASE_ADDR) < rom_valid && (p - ROM_BASE_ADDR) < ROM_BYTES;
    return p < RAM_BYTES || (p >= RCR_BASE && p - RCR_BASE < RCR_LEN) ||
           (p >= SPD_BASE && p - SPD_BASE < SP_MEM_BYTES) ||
           (p >= SPI_BASE && p - SPI_BASE < SP_MEM_BYTES) ||
           (p >= MI_BASE && p - MI_BASE < MI_LEN) ||
           (p >= PI_BASE && p - PI_BASE < PI_LEN) ||
           (p >= RI_BASE && p - RI_BASE < RI_LEN) || rom_ok;
  endfunction

  function automatic logic [7:0] fetch_byte(logic [31:0] p, inout logic bad);
    if (decodes(p, 1'b0)) begin
      if (phys_img.exists(p)) return phys_img[p];
      touches_unwritten = 1'b1;
      return 8'h00;
    end
    bad = 1'b1;
    return 8'hFF;
  endfunction

  function automatic void poke(logic [31:0] key, logic [7:0] v);
    undo_log.push_back('{key, phys_img.exists(key), phys_img.exists(key) ? phys_img[key] : 8'h00});
    phys_img[key] = v;
  endfunction

  // Returns 1 when the byte completes the PI write-length word.
  function automatic logic store_byte(logic [31:0] p, logic [7:0] v, inout logic bad);
    if (decodes(p, 1'b1)) begin
      poke(p, v);
      return p == PI_BASE + PI_LEN_IDX;
    end
    bad = 1'b1;
    return 1'b0;
  endfunction

  function automatic logic [31:0] pi_word(int unsigned at);
    return {phys_img[PI_BASE + at], phys_img[PI_BASE + at + 1],
            phys_img[PI_BASE + at + 2], phys_img[PI_BASE + at + 3]};
  endfunction

  function automatic void pi_copy();
    logic [31:0] dst, src, len_word;
    int unsigned len;
    logic ignore;
    logic [7:0] b;
    dst = pi_word(0);
    src = pi_word(4);
    len_word = pi_word(12);
    len = int'(len_word[DMA_LEN_BITS-1:0]) + 1;
    ignore = 1'b0;
    // Long copies are kept out of the stimulus to bound the run time.
    if (len > MAX_COPY) begin
      touches_unwritten = 1'b1;
      return;
    end
    for (int unsigned i = 0; i < len; i++) begin
      b = fetch_byte(src + i, ignore);
      void'(store_byte(dst + i, b, ignore));
    end
  endfunction

  function automatic access_res_t predict_access(item_t it);
    access_res_t r;
    int unsigned n;
    logic bad_phys, bad_seg;
    logic [31:0] va, off;
    logic [63:0] sh, sign;
    logic [7:0] b;
    r = '0;
    bad_phys = 1'b0;
    bad_seg = 1'b0;
    n = 1 << it.size;
    case (it.cmd)
      CMD_READ: begin
        for (int unsigned i = 0; i < n; i++) begin
          va = it.addr + i;
          b = 8'hFF;
          if (va >= KSEG_LO && va < KSEG_HI) b = fetch_byte(va & PHYS_MASK, bad_phys);
          else bad_seg = 1'b1;
          r.rdata = {r.rdata[55:0], b};
        end
        if (it.sext && n < 8) begin
          sign = 64'd1 << (8 * n - 1);
          r.rdata = (r.rdata ^ sign) - sign;
        end
      end
      CMD_WRITE: begin
        for (int unsigned i = 0; i < n; i++) begin
          va = it.addr + i;
          sh = it.wdata >> (8 * (n - 1 - i));
          if (va >= KSEG_LO && va < KSEG_HI) begin
            if (store_byte(va & PHYS_MASK, sh[7:0], bad_phys)) begin
              pi_copy();
              r.ran = 1'b1;
            end
          end else begin
            bad_seg = 1'b1;
          end
        end
      end
      CMD_LOAD: begin
        off = it.addr ^ (rom_order == 2'd1 ? 32'd3 : (rom_order == 2'd2 ? 32'd1 : 32'd0));
        if (off < ROM_BYTES) poke(ROM_BASE_ADDR + off, it.wdata[7:0]);
        else bad_phys = 1'b1;
      end
      default: ;
    endcase
    r.st = bad_seg ? ST_SEG : (bad_phys ? ST_PHYS : ST_OK);
    return r;
  endfunction

  // Queues the access unless it would read a never-written memory byte or run a long copy.
  function automatic logic try_queue(item_t it);
    access_res_t r;
    undo_log.delete();
    touches_unwritten = 1'b0;
    r = predict_access(it);
    if (touches_unwritten) begin
      for (int i = undo_log.size() - 1; i >= 0; i--) begin
        if (undo_log[i].had) phys_img[undo_log[i].key] = undo_log[i].old;
        else phys_img.delete(undo_log[i].key);
      end
      return 1'b0;
    end
    pending_q.push_back('{it, r});
    return 1'b1;
  endfunction

  function automatic item_t mk(cmd_e c, logic [31:0] a, logic [1:0] s, logic [63:0] d, logic x);
    item_t it;
    it.cmd = c;
    it.addr = a;
    it.size = s;
    it.wdata = d;
    it.sext = x;
    return it;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic void add_access(item_t it);
    if (!try_queue(it))
      void'(try_queue(mk(CMD_WRITE, KSEG_LO + 8 * $urandom_range(0, 15), 2'd3, rand64(), 1'b0)));
  endfunction

  function automatic logic [31:0] pick_phys();
    case ($urandom_range(0, 10))
      0, 1: return $urandom_range(0, 127);
      2: return RAM_BYTES - 8 + $urandom_range(0, 15);
      3: return RCR_BASE - 4 + $urandom_range(0, 47);
      4: return SPD_BASE + $urandom_range(0, 31);
      5: return SPI_BASE + SP_MEM_BYTES - 8 + $urandom_range(0, 15);
      6: return MI_BASE - 2 + $urandom_range(0, 20);
      7: return PI_BASE + $urandom_range(0, 59);
      8: return RI_BASE + $urandom_range(0, 35);
      9: return ROM_BASE_ADDR + $urandom_range(0, 127);
      default: return ROM_BASE_ADDR + rom_valid - 4 + $urandom_range(0, 7);
    endcase
  endfunction

  function automatic logic [31:0] pick_virt();
    case ($urandom_range(0, 19))
      0: return $urandom;
      1: return 32'h7FFF_FFFC + $urandom_range(0, 7);
      2: return 32'hBFFF_FFFC + $urandom_range(0, 7);
      3: return 32'hFFFF_FFFC + $urandom_range(0, 7);
      4, 5, 6, 7, 8, 9, 10, 11: return KSEG_LO | pick_phys();
      default: return KSEG_UNCACHED | pick_phys();
    endcase
  endfunction

  function automatic logic [31:0] pick_rom_offset();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return rom_valid - 4 + $urandom_range(0, 7);
      2: return ROM_BYTES - 4 + $urandom_range(0, 7);
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  // Programs destination, source and length; the last write starts the copy.
  function automatic void add_copy_sequence();
    logic [31:0] dst, src;
    case ($urandom_range(0, 3))
      0: dst = SPD_BASE + $urandom_range(0, 100);
      1: dst = RAM_BYTES - 8 + $urandom_range(0, 7);
      default: dst = $urandom_range(0, 120);
    endcase
    case ($urandom_range(0, 2))
      0: src = $urandom_range(0, 120);
      default: src = ROM_BASE_ADDR + $urandom_range(0, 120);
    endcase
    add_access(mk(CMD_WRITE, KSEG_UNCACHED | PI_BASE, 2'd2, {32'h0, dst}, 1'b0));
    add_access(mk(CMD_WRITE, KSEG_LO | (PI_BASE + 4), 2'd2, {32'h0, src}, 1'b0));
    add_access(mk(CMD_WRITE, KSEG_LO | (PI_BASE + 8), 2'd3,
                  {32'($urandom), 8'($urandom), 24'($urandom_range(0, 15))}, 1'b0));
  endfunction

  function automatic void add_random(int unsigned count);
    int unsigned target;
    item_t it;
    logic ok;
    target = pending_q.size() + count;
    while (pending_q.size() < target) begin
      if ($urandom_range(0, 99) < 20) begin
        add_copy_sequence();
      end else begin
        ok = 1'b0;
        for (int k = 0; k < 20 && !ok; k++) begin
          case ($urandom_range(0, 19))
            0: it = mk(CMD_NONE, $urandom, 2'($urandom), rand64(), 1'($urandom));
            1, 2, 3, 4: it = mk(CMD_LOAD, pick_rom_offset(), 2'($urandom), rand64(),
                                1'($urandom));
            5, 6, 7, 8, 9, 10, 11: it = mk(CMD_WRITE, pick_virt(), 2'($urandom), rand64(),
                                           1'($urandom));
            default: it = mk(CMD_READ, pick_virt(), 2'($urandom), rand64(), 1'($urandom));
          endcase
          ok = try_queue(it);
        end
        if (!ok) add_access(it);
      end
    end
  endfunction

  function automatic void add_directed();
    add_access(mk(CMD_WRITE, KSEG_LO, 2'd3, 64'h8081_FF7F_0102_A5C3, 1'b0));
    add_access(mk(CMD_READ, KSEG_LO, 2'd3, '0, 1'b0));
    add_access(mk(CMD_READ, KSEG_UNCACHED, 2'd0, '0, 1'b1));
    add_access(mk(CMD_READ, KSEG_LO, 2'd1, '0, 1'b1));
    add_access(mk(CMD_READ, KSEG_LO + 2, 2'd2, '0, 1'b1));
    add_access(mk(CMD_READ, KSEG_LO + 3, 2'd0, '0, 1'b1));
    add_access(mk(CMD_WRITE, KSEG_UNCACHED | (RAM_BYTES - 4), 2'd3, '1, 1'b0));
    add_access(mk(CMD_READ, 32'h7FFF_FFFC, 2'd3, '0, 1'b0));
    add_access(mk(CMD_READ, 32'hBFFF_FFFC, 2'd3, '0, 1'b1));
    add_access(mk(CMD_WRITE, 32'hFFFF_FFFC, 2'd3, rand64(), 1'b0));
    add_access(mk(CMD_WRITE, KSEG_LO | (RCR_BASE + RCR_LEN - 4), 2'd3, rand64(), 1'b0));
    add_access(mk(CMD_READ, KSEG_LO | (MI_BASE + MI_LEN - 4), 2'd3, '0, 1'b0));
    add_access(mk(CMD_WRITE, KSEG_LO | (RI_BASE + RI_LEN - 2), 2'd2, rand64(), 1'b0));
    add_access(mk(CMD_WRITE, KSEG_LO | (SPI_BASE - 4), 2'd3, rand64(), 1'b0));
    add_access(mk(CMD_READ, KSEG_LO | (SPI_BASE - 4), 2'd3, '0, 1'b0));
    add_access(mk(CMD_LOAD, 32'h0, 2'd0, 64'h5A, 1'b0));
    add_access(mk(CMD_LOAD, 32'hFFFF_FFFF, 2'd3, rand64(), 1'b1));
    add_access(mk(CMD_WRITE, KSEG_LO | ROM_BASE_ADDR, 2'd0, rand64(), 1'b0));
    add_access(mk(CMD_READ, KSEG_LO | ROM_BASE_ADDR, 2'd0, '0, 1'b0));
    add_access(mk(CMD_NONE, $urandom, 2'd3, rand64(), 1'b1));
    // Copy of eight RAM bytes into RAM, then a copy that lands on the length word.
    add_access(mk(CMD_WRITE, KSEG_LO | PI_BASE, 2'd3, {32'h0000_0100, 32'h0}, 1'b0));
    add_access(mk(CMD_WRITE, KSEG_LO | (PI_BASE + 8), 2'd3, 64'hFF00_0000_FF00_0007, 1'b0));
    add_access(mk(CMD_WRITE, KSEG_LO | PI_BASE, 2'd2, {32'h0, PI_BASE + 8}, 1'b0));
    add_access(mk(CMD_WRITE, KSEG_LO | (PI_BASE + 12), 2'd2, 64'h7, 1'b0));
    add_access(mk(CMD_READ, KSEG_LO | (PI_BASE + 8), 2'd3, '0, 1'b0));
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [24:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_ORDER) rom_order = val[1:0];
    else rom_valid = val;
  endtask

  task automatic run_phase(logic [1:0] order, logic [24:0] size, int unsigned idle,
                           logic directed);
    while (pending_q.size() != 0 || awaited_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    write_reg(CFG_ORDER, order);
    write_reg(CFG_SIZE, size);
    idle_pct = idle;
    if (directed) add_directed();
    add_random(PHASE_ITEMS);
  endtask

  // Command driver: the head of the pending queue is offered until accepted.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      if (start_i && !busy_o) begin
        awaited_q.push_back(pending_q[0].res);
        pending_q.pop_front();
      end
      if (start_i && busy_o) begin
        start_i <= 1'b1;
      end else if (pending_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        start_i <= 1'b1;
        command_i <= pending_q[0].it.cmd;
        address_i <= pending_q[0].it.addr;
        access_size_i <= pending_q[0].it.size;
        write_data_i <= pending_q[0].it.wdata;
        sign_extend_i <= pending_q[0].it.sext;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (awaited_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: data %h status %0d copy %0b",
                                       read_data_o, status_o, dma_ran_o);
      end else begin
        if (read_data_o !== awaited_q[0].rdata || status_o !== awaited_q[0].st ||
            dma_ran_o !== awaited_q[0].ran) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected data %h status %0d copy %0b, got %h %0d %0b",
                     awaited_q[0].rdata, awaited_q[0].st, awaited_q[0].ran,
                     read_data_o, status_o, dma_ran_o);
        end
        awaited_q.pop_front();
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_console_memory_map_with_pi_dma_core: done, errors");
      $finish;
    end
  end

  initial begin
    for (int unsigned i = 0; i < RCR_LEN; i++) phys_img[RCR_BASE + i] = 8'h00;
    for (int unsigned i = 0; i < MI_LEN; i++) phys_img[MI_BASE + i] = 8'h00;
    for (int unsigned i = 0; i < PI_LEN; i++) phys_img[PI_BASE + i] = 8'h00;
    for (int unsigned i = 0; i < RI_LEN; i++) phys_img[RI_BASE + i] = 8'h00;
    rom_order = 2'd0;
    rom_valid = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    run_phase(2'd0, 25'd0, 0, 1'b1);
    run_phase(2'd1, 25'd256, 80, 1'b0);
    run_phase(2'd2, 25'd16777216, 0, 1'b0);
    run_phase(2'd0, 25'd128, 31, 1'b0);
    run_phase(2'd2, 25'd0, 0, 1'b0);
    while (pending_q.size() != 0 || awaited_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_console_memory_map_with_pi_dma_core: done, clean");
    end else begin
      $display("tb_console_memory_map_with_pi_dma_core: done, errors");
    end
    $finish;
  end

endmodule

FILE: console_memory_map_with_pi_dma_core.f
sv/cmm_pkg.sv
sv/cmm_front.sv
sv/cmm_back.sv
sv/console_memory_map_with_pi_dma_core.sv
tb/tb_console_memory_map_with_pi_dma_core.sv
